@@ design/rtt_pkg.sv @@
// Shared types and constants of the retransmit timeout table.
package rtt_pkg;

	// Sizes
	localparam int SLOTS_DEF = 32;
	localparam int FREE_W    = 6;
	localparam int SLOT_W    = 5;
	localparam int TICK_W    = 16;
	localparam int RETRY_W   = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Command codes
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_INSERT  = 2'd1;
	localparam logic [1:0] FUNC_RELEASE = 2'd2;

	// Result event codes
	localparam logic [1:0] EV_RESEND  = 2'd0;
	localparam logic [1:0] EV_DROPPED = 2'd1;
	localparam logic [1:0] EV_DONE    = 2'd2;
	localparam logic [1:0] EV_ERROR   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INI = 2'd2;

	// Reset values of the configuration registers
	localparam logic [TICK_W-1:0]  TIMEOUT_RST   = 16'd10;
	localparam logic [RETRY_W-1:0] RETRY_RST     = 8'd3;
	localparam logic [RETRY_W-1:0] RETRY_INI_RST = 8'd3;

	typedef struct packed {
		logic [1:0]        func;
		logic [SLOT_W-1:0] slot;
		logic              initial_info;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        event_res;
		logic [SLOT_W-1:0] slot_index;
		logic [FREE_W-1:0] free_slots;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [TICK_W-1:0]  timeout_limit;
		logic [RETRY_W-1:0] retry_limit;
		logic [RETRY_W-1:0] retry_limit_initial;
	} cfg_t;

	// One slot entry as held in the slot memory
	typedef struct packed {
		logic               sent;
		logic               ini;
		logic [TICK_W-1:0]  ticks;
		logic [RETRY_W-1:0] retries;
	} entry_t;

	// Requests from the sequencer to the slot table
	typedef struct packed {
		logic walk;
		logic insert;
		logic rel;
		logic ini;
	} tbl_ctl_t;

	// Walk outcome of the slot in the update stage
	typedef struct packed {
		logic emit;
		logic dropped;
	} tbl_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

@@ design/rtt_slot_table.sv @@
// Slot memory with in-use flags and the read-modify-write tick update.
module rtt_slot_table #(
	parameter int SLOTS = rtt_pkg::SLOTS_DEF,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtt_pkg::cfg_t        cfg,
	input  rtt_pkg::tbl_ctl_t    ctl,
	input  logic [AW-1:0]        addr,
	output logic                 hit,
	output rtt_pkg::tbl_stat_t   stat,
	output logic [AW-1:0]        stat_idx
);
	import rtt_pkg::*;

	entry_t             mem [SLOTS];
	logic [SLOTS-1:0]   in_use_q;
	entry_t             rd_s1;
	logic               walk_s1;
	logic [AW-1:0]      idx_s1;

	logic               live_s1;
	logic [TICK_W-1:0]  ticks_inc;
	logic               timed_out;
	logic               resend;
	logic [RETRY_W-1:0] retries_inc;
	logic [RETRY_W-1:0] lim;
	logic               drop;
	entry_t             wb;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	entry_t             mem_wd;

	// In-use lookup for insert and release; caller keeps addr in range
	assign hit = in_use_q[addr];

	// Read stage: one slot per cycle during a walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_s1 <= 1'b0;
		end else begin
			walk_s1 <= ctl.walk;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr;
		if (ctl.walk) begin
			rd_s1 <= mem[addr];
		end
	end

	// Update stage: timeout, resend and retry limit
	always_comb begin
		live_s1     = walk_s1 & in_use_q[idx_s1];
		ticks_inc   = (rd_s1.ticks == '1) ? rd_s1.ticks : rd_s1.ticks + TICK_W'(1);
		timed_out   = rd_s1.sent & (ticks_inc > cfg.timeout_limit);
		resend      = ~rd_s1.sent | timed_out;
		retries_inc = (rd_s1.retries == '1) ? rd_s1.retries
			: rd_s1.retries + RETRY_W'(1);
		lim         = rd_s1.ini ? cfg.retry_limit_initial : cfg.retry_limit;
		drop        = resend & (retries_inc > lim);

		wb.sent    = 1'b1;
		wb.ini     = rd_s1.ini;
		wb.ticks   = resend ? '0 : ticks_inc;
		wb.retries = resend ? retries_inc : rd_s1.retries;

		stat.emit    = live_s1 & resend;
		stat.dropped = live_s1 & drop;
		stat_idx     = idx_s1;
	end

	// Write port: insert from idle, write-back from the walk
	always_comb begin
		mem_we = ctl.insert | live_s1;
		mem_wa = ctl.insert ? addr : idx_s1;
		if (ctl.insert) begin
			mem_wd.sent    = 1'b1;
			mem_wd.ini     = ctl.ini;
			mem_wd.ticks   = '0;
			mem_wd.retries = '0;
		end else begin
			mem_wd = wb;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// In-use flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else begin
			if (ctl.insert) begin
				in_use_q[addr] <= 1'b1;
			end
			if (ctl.rel) begin
				in_use_q[addr] <= 1'b0;
			end
			if (live_s1 && drop) begin
				in_use_q[idx_s1] <= 1'b0;
			end
		end
	end

endmodule

@@ design/retransmit_timeout_table.sv @@
// Top level of the retransmit timeout table: sequencer, config, free count, result register.
//
//  channel   handshake               payload
//  command   start, busy             cmd   (func, slot, initial_info)
//  result    valid                   res   (event_res, slot_index, free_slots, last)
//  config    cfg_we                  cfg_index, cfg_data
//
// Insert, release and error commands leave busy low; the result shows the next
// cycle. A tick walks the slot memory one slot per cycle through a read stage
// and an update stage, holding busy through the walk, drain and finish states;
// its done result follows in the cycle after the finish state.
// Reset clears all slots and loads the config registers with their defaults.
// Results are strobed for one cycle on valid; the receiver cannot stall them.
module retransmit_timeout_table #(
	parameter int SLOTS = rtt_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  rtt_pkg::cmd_t                   cmd,
	output logic                            busy,
	output logic                            valid,
	output rtt_pkg::res_t                   res,
	input  logic                            cfg_we,
	input  logic [rtt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtt_pkg::CFG_W-1:0]       cfg_data
);
	import rtt_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	cfg_t              cfg_q;
	state_t            state_q, state_d;
	logic [AW-1:0]     ptr_q;
	logic [FREE_W-1:0] free_q, free_d;
	logic              valid_q, valid_d;
	res_t              res_q, res_d;

	logic              accept;
	logic              in_range;
	logic              ins_ok;
	logic              rel_ok;
	logic              hit;
	logic [AW-1:0]     addr;
	tbl_ctl_t          ctl;
	tbl_stat_t         stat;
	logic [AW-1:0]     stat_idx;

	rtt_slot_table #(
		.SLOTS(SLOTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.ctl      (ctl),
		.addr     (addr),
		.hit      (hit),
		.stat     (stat),
		.stat_idx (stat_idx)
	);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_limit       <= TIMEOUT_RST;
			cfg_q.retry_limit         <= RETRY_RST;
			cfg_q.retry_limit_initial <= RETRY_INI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT:   cfg_q.timeout_limit       <= cfg_data;
				CFG_RETRY:     cfg_q.retry_limit         <= cfg_data[RETRY_W-1:0];
				CFG_RETRY_INI: cfg_q.retry_limit_initial <= cfg_data[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	// Command decode
	always_comb begin
		accept   = start & (state_q == ST_IDLE);
		in_range = 32'(cmd.slot) < 32'(SLOTS);
		addr     = (state_q == ST_IDLE) ? AW'(cmd.slot) : ptr_q;
		ins_ok   = accept & (cmd.func == FUNC_INSERT) & in_range & ~hit;
		rel_ok   = accept & (cmd.func == FUNC_RELEASE) & in_range & hit;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.func == FUNC_TICK) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (ptr_q == AW'(SLOTS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy       = (state_q != ST_IDLE);
		ctl.walk   = (state_q == ST_WALK);
		ctl.insert = ins_ok;
		ctl.rel    = rel_ok;
		ctl.ini    = cmd.initial_info;
	end

	// Free count, kept saturating in step with the in-use flags
	always_comb begin
		free_d = free_q;
		if (ins_ok && free_q != '0) begin
			free_d = free_q - FREE_W'(1);
		end else if ((rel_ok || stat.dropped) && free_q < FREE_W'(SLOTS)) begin
			free_d = free_q + FREE_W'(1);
		end
	end

	// Result selection
	always_comb begin
		valid_d          = 1'b0;
		res_d.event_res  = EV_DONE;
		res_d.slot_index = '0;
		res_d.free_slots = free_d;
		res_d.last       = 1'b1;
		if (accept && cmd.func != FUNC_TICK) begin
			valid_d         = 1'b1;
			res_d.event_res = (ins_ok || rel_ok) ? EV_DONE : EV_ERROR;
		end else if (stat.emit) begin
			valid_d          = 1'b1;
			res_d.event_res  = stat.dropped ? EV_DROPPED : EV_RESEND;
			res_d.slot_index = SLOT_W'(stat_idx);
			res_d.last       = 1'b0;
		end else if (state_q == ST_FINISH) begin
			valid_d = 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			free_q  <= FREE_W'(SLOTS);
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			valid_q <= valid_d;
			if (accept) begin
				ptr_q <= '0;
			end else if (state_q == ST_WALK) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign valid = valid_q;
	assign res   = res_q;

endmodule

@@ bench/rtt_checker.sv @@
// Checker for the retransmit timeout table: tracks the slot table and compares every result.
module rtt_checker
	import rtt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  cmd_t                 cmd,
	input  logic                 valid,
	input  res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   outstanding,
	output int                   resends_seen,
	output int                   drops_seen
);

	localparam int PRINT_CAP = 50;

	// Shadow of the slot table and the config registers
	logic               in_use   [SLOTS];
	logic               sent     [SLOTS];
	logic               ini      [SLOTS];
	logic [TICK_W-1:0]  ticks    [SLOTS];
	logic [RETRY_W-1:0] retries  [SLOTS];
	logic [FREE_W-1:0]  free_left;
	logic [TICK_W-1:0]  timeout_lim;
	logic [RETRY_W-1:0] retry_lim;
	logic [RETRY_W-1:0] retry_lim_ini;

	// Results the table still owes, oldest first
	res_t due_results[$];

	task automatic report_mismatch(string what, res_t got, res_t want);
		if (fail_count < PRINT_CAP)
			$display("%0t: %s: got ev=%0d slot=%0d free=%0d last=%0d, want ev=%0d slot=%0d free=%0d last=%0d",
				$time, what, got.event_res, got.slot_index, got.free_slots, got.last,
				want.event_res, want.slot_index, want.free_slots, want.last);
		fail_count++;
	endtask

	function automatic void owe_result(logic [1:0] ev, int idx, logic last);
		res_t r;
		r.event_res  = ev;
		r.slot_index = SLOT_W'(idx);
		r.free_slots = free_left;
		r.last       = last;
		due_results.push_back(r);
	endfunction

	// Apply one accepted transfer to the shadow table and queue what it yields
	function automatic void apply_command(cmd_t c);
		logic [RETRY_W-1:0] lim;
		logic               drop;
		case (c.func)
			FUNC_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!in_use[i])
						continue;
					if (sent[i]) begin
						if (ticks[i] != '1)
							ticks[i]++;
						if (ticks[i] > timeout_lim)
							sent[i] = 1'b0;
					end
					if (sent[i])
						continue;
					sent[i]  = 1'b1;
					ticks[i] = '0;
					if (retries[i] != '1)
						retries[i]++;
					lim  = ini[i] ? retry_lim_ini : retry_lim;
					drop = retries[i] > lim;
					if (drop) begin
						in_use[i] = 1'b0;
						if (free_left < SLOTS)
							free_left++;
					end
					owe_result(drop ? EV_DROPPED : EV_RESEND, i, 1'b0);
				end
				owe_result(EV_DONE, 0, 1'b1);
			end
			FUNC_INSERT: begin
				if (int'(c.slot) < SLOTS && !in_use[c.slot]) begin
					in_use[c.slot]  = 1'b1;
					sent[c.slot]    = 1'b1;
					ini[c.slot]     = c.initial_info;
					ticks[c.slot]   = '0;
					retries[c.slot] = '0;
					if (free_left > 0)
						free_left--;
					owe_result(EV_DONE, 0, 1'b1);
				end else begin
					owe_result(EV_ERROR, 0, 1'b1);
				end
			end
			FUNC_RELEASE: begin
				if (int'(c.slot) < SLOTS && in_use[c.slot]) begin
					in_use[c.slot] = 1'b0;
					if (free_left < SLOTS)
						free_left++;
					owe_result(EV_DONE, 0, 1'b1);
				end else begin
					owe_result(EV_ERROR, 0, 1'b1);
				end
			end
			default: begin
				owe_result(EV_ERROR, 0, 1'b1);
			end
		endcase
	endfunction

	// Watch all three channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				in_use[i]  = 1'b0;
				sent[i]    = 1'b0;
				ini[i]     = 1'b0;
				ticks[i]   = '0;
				retries[i] = '0;
			end
			free_left     = FREE_W'(SLOTS);
			timeout_lim   = TIMEOUT_RST;
			retry_lim     = RETRY_RST;
			retry_lim_ini = RETRY_INI_RST;
			due_results.delete();
			fail_count   = 0;
			resends_seen = 0;
			drops_seen   = 0;
		end else begin
			if (valid) begin
				if (res.event_res == EV_RESEND)
					resends_seen++;
				if (res.event_res == EV_DROPPED)
					drops_seen++;
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing expected", res, '0);
				end else begin
					want = due_results.pop_front();
					if (res.event_res !== want.event_res)
						report_mismatch("event_res", res, want);
					if (res.slot_index !== want.slot_index)
						report_mismatch("slot_index", res, want);
					if (res.free_slots !== want.free_slots)
						report_mismatch("free_slots", res, want);
					if (res.last !== want.last)
						report_mismatch("last", res, want);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT:   timeout_lim   = cfg_data[TICK_W-1:0];
					CFG_RETRY:     retry_lim     = cfg_data[RETRY_W-1:0];
					CFG_RETRY_INI: retry_lim_ini = cfg_data[RETRY_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				apply_command(cmd);
		end
		outstanding = due_results.size();
	end

endmodule

@@ bench/retransmit_timeout_table_test.sv @@
// Testbench top of the retransmit timeout table: stimulus, config phases and verdict.
module retransmit_timeout_table_test;
	import rtt_pkg::*;

	localparam int         SLOTS       = SLOTS_DEF;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         PHASES      = 7;
	localparam int         PHASE_ITEMS = 26;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	cmd_t                 cmd;
	logic                 busy;
	logic                 valid;
	res_t                 res;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count;
	int outstanding;
	int resends_seen;
	int drops_seen;
	int cycle_count;
	int func_counts[4];
	int cfg_writes;

	retransmit_timeout_table #(.SLOTS(SLOTS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.valid     (valid),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rtt_checker #(.SLOTS(SLOTS)) table_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.valid        (valid),
		.res          (res),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.resends_seen (resends_seen),
		.drops_seen   (drops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
			$display("retransmit_timeout_table test failed");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer, start left high
	task automatic send_command(logic [1:0] func, int slot, logic initial_info);
		start            = 1'b1;
		cmd.func         = func;
		cmd.slot         = SLOT_W'(slot);
		cmd.initial_info = initial_info;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		func_counts[func]++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_writes++;
	endtask

	task automatic set_limits(int timeout_lim, int retry_lim, int retry_lim_ini);
		write_reg(CFG_TIMEOUT, timeout_lim);
		write_reg(CFG_RETRY, retry_lim);
		write_reg(CFG_RETRY_INI, retry_lim_ini);
	endtask

	// Drop start, let every owed result come back, then leave a walk's worth of slack
	task automatic wait_idle();
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SLOTS + 6) @(negedge clk);
	endtask

	task automatic idle_gap();
		int gap;
		gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
		start = (gap == 0);
		repeat (gap) @(negedge clk);
	endtask

	// Random commands in bursts; a narrow slot window makes inserts and releases collide
	task automatic run_items(int count, int window);
		int         left;
		int         burst;
		int         pick;
		logic [1:0] func;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				pick = $urandom_range(99);
				if (pick < 35)
					func = FUNC_TICK;
				else if (pick < 68)
					func = FUNC_INSERT;
				else if (pick < 95)
					func = FUNC_RELEASE;
				else
					func = FUNC_UNUSED;
				send_command(func, $urandom_range(window - 1), 1'($urandom_range(1)));
				burst--;
				left--;
			end
			idle_gap();
		end
	endtask

	initial begin
		int timeout_lim;
		int retry_lim;
		int retry_lim_ini;

		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, reset limits: empty tick, busy and free slot errors, unused code
		send_command(FUNC_TICK, 0, 1'b0);
		send_command(FUNC_INSERT, 0, 1'b0);
		send_command(FUNC_INSERT, 31, 1'b1);
		send_command(FUNC_INSERT, 0, 1'b1);
		send_command(FUNC_RELEASE, 5, 1'b0);
		send_command(FUNC_UNUSED, 31, 1'b1);
		send_command(FUNC_RELEASE, 31, 1'b0);
		send_command(FUNC_INSERT, 31, 1'b1);
		send_command(FUNC_TICK, 0, 1'b0);
		send_command(FUNC_RELEASE, 0, 1'b0);
		send_command(FUNC_RELEASE, 0, 1'b0);
		wait_idle();

		// Directed, zero timeout: resend on every tick, drops at distinct limits
		set_limits(0, 0, 1);
		send_command(FUNC_INSERT, 1, 1'b0);
		send_command(FUNC_INSERT, 2, 1'b1);
		send_command(FUNC_TICK, 0, 1'b0);
		send_command(FUNC_TICK, 0, 1'b0);
		send_command(FUNC_TICK, 0, 1'b0);
		send_command(FUNC_RELEASE, 2, 1'b0);
		wait_idle();

		// Random phases, each under its own limits
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin timeout_lim = 0;     retry_lim = 0;   retry_lim_ini = 0;   end
				1: begin timeout_lim = 65534; retry_lim = 254; retry_lim_ini = 254; end
				2: begin timeout_lim = 1;     retry_lim = 2;   retry_lim_ini = 0;   end
				3: begin timeout_lim = 2;     retry_lim = 0;   retry_lim_ini = 254; end
				4, 5: begin
					timeout_lim   = $urandom_range(6);
					retry_lim     = $urandom_range(4);
					retry_lim_ini = $urandom_range(4);
				end
				default: begin
					timeout_lim   = TIMEOUT_RST;
					retry_lim     = RETRY_RST;
					retry_lim_ini = RETRY_INI_RST;
				end
			endcase
			set_limits(timeout_lim, retry_lim, retry_lim_ini);
			run_items(PHASE_ITEMS, (phase % 2 == 1) ? SLOTS : 8);
			wait_idle();
		end

		// Long retry runs under high limits; the initial-info slot goes one tick earlier
		set_limits(0, 100, 99);
		send_command(FUNC_INSERT, 3, 1'b0);
		send_command(FUNC_INSERT, 4, 1'b1);
		for (int n = 0; n < 102; n++) begin
			send_command(FUNC_TICK, 0, 1'b0);
			if ($urandom_range(15) == 0)
				idle_gap();
		end
		wait_idle();

		$display("covered %0d ticks, %0d inserts, %0d releases, %0d unused codes, %0d register writes",
			func_counts[FUNC_TICK], func_counts[FUNC_INSERT], func_counts[FUNC_RELEASE],
			func_counts[FUNC_UNUSED], cfg_writes);
		$display("observed %0d resends and %0d drops, %0d mismatches",
			resends_seen, drops_seen, fail_count);
		if (fail_count == 0)
			$display("retransmit_timeout_table test passed");
		else
			$display("retransmit_timeout_table test failed");
		$finish;
	end

endmodule

@@ retransmit_timeout_table.f @@
design/rtt_pkg.sv
design/rtt_slot_table.sv
design/retransmit_timeout_table.sv
bench/rtt_checker.sv
bench/retransmit_timeout_table_test.sv
